// File: sv/molecule_pool_exp_euler_step_core_assert.svh
// Assertion macros used by the core module.
`ifndef MOLECULE_POOL_EXP_EULER_STEP_CORE_ASSERT_SVH
`define MOLECULE_POOL_EXP_EULER_STEP_CORE_ASSERT_SVH

`define MPE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define MPE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/mpe_pkg.sv
package mpe_pkg;

    localparam logic [1:0] KIND_RATES  = 2'd0;
    localparam logic [1:0] KIND_TICK   = 2'd1;
    localparam logic [1:0] KIND_REINIT = 2'd2;
    localparam logic [1:0] KIND_SET    = 2'd3;

    localparam logic REG_INIT_COUNT = 1'b0;
    localparam logic REG_TIME_STEP  = 1'b1;

    localparam logic [63:0] ONE63 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] XLIM  = 64'h0000_0020_0000_0000;
    localparam logic [3:0]  HORNER_TERMS = 4'd10;
    localparam logic [3:0]  SQUARINGS = 4'd8;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV
    } alu_op_t;

    typedef enum logic [1:0] {
        ALU_IDLE,
        ALU_MUL,
        ALU_DIV
    } alu_state_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BD,
        ST_X,
        ST_HMUL,
        ST_HDIV,
        ST_SQ,
        ST_T1,
        ST_DN,
        ST_DA,
        ST_T2,
        ST_FWD
    } seq_state_t;

    typedef struct packed {
        logic          start;
        alu_op_t       op;
        logic          wide;
        logic [63:0]   a;
        logic [63:0]   b;
        logic [127:0]  dividend;
        logic [63:0]   den;
    } alu_req_t;

    typedef struct packed {
        logic          done;
        logic [127:0]  prod;
        logic [63:0]   quo;
        logic          quo_ovf;
    } alu_rsp_t;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] cmax);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, cmax}) ? cmax : s[63:0];
    endfunction

endpackage

// File: sv/mpe_alu.sv
module mpe_alu
    import mpe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    alu_state_t state_reg, state_next;
    logic [6:0]   cnt_reg;
    logic [63:0]  a_reg, b_reg, den_reg, r_reg, q_reg;
    logic [127:0] acc_reg, dv_reg;
    logic         qnz_reg, done_reg, last;

    logic [31:0]  ah, bh;
    logic [63:0]  pp;
    logic [6:0]   shamt;
    logic [64:0]  rsh;
    logic         qb;

    assign ah    = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign bh    = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
    assign pp    = ah * bh;
    assign shamt = {cnt_reg[1] & cnt_reg[0], cnt_reg[1] ^ cnt_reg[0], 5'b0};
    assign rsh   = {r_reg, dv_reg[127]};
    assign qb    = rsh >= {1'b0, den_reg};
    assign last  = (state_reg == ALU_MUL) ? (cnt_reg == 7'd3) : (cnt_reg == 7'd0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ALU_IDLE:
            begin
                if (req.start)
                begin
                    state_next = (req.op == OP_MUL) ? ALU_MUL : ALU_DIV;
                end
            end
            ALU_MUL, ALU_DIV:
            begin
                if (last)
                begin
                    state_next = ALU_IDLE;
                end
            end
            default: state_next = ALU_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ALU_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg != ALU_IDLE) && last;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ALU_IDLE:
            begin
                if (req.start)
                begin
                    a_reg   <= req.a;
                    b_reg   <= req.b;
                    den_reg <= req.den;
                    r_reg   <= 64'd0;
                    q_reg   <= 64'd0;
                    qnz_reg <= 1'b0;
                    if (req.op == OP_MUL)
                    begin
                        acc_reg <= 128'd0;
                        cnt_reg <= 7'd0;
                    end
                    else
                    begin
                        dv_reg  <= req.wide ? req.dividend : {req.dividend[63:0], 64'd0};
                        cnt_reg <= req.wide ? 7'd127 : 7'd63;
                    end
                end
            end
            ALU_MUL:
            begin
                acc_reg <= acc_reg + (128'(pp) << shamt);
                cnt_reg <= cnt_reg + 7'd1;
            end
            ALU_DIV:
            begin
                dv_reg  <= {dv_reg[126:0], 1'b0};
                r_reg   <= qb ? 64'(rsh - {1'b0, den_reg}) : rsh[63:0];
                q_reg   <= {q_reg[62:0], qb};
                qnz_reg <= qnz_reg | q_reg[63];
                cnt_reg <= cnt_reg - 7'd1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rsp.done    = done_reg;
        rsp.prod    = acc_reg;
        rsp.quo     = q_reg;
        rsp.quo_ovf = qnz_reg;
    end

endmodule

// File: sv/molecule_pool_exp_euler_step_core.sv
// Molecule pool integrator with a fixed-point exponential Euler step.
// Requests arrive on in_valid/in_ready with kind, rate_in, rate_out and
// count_value. A rate request adds to the rate sums, a set request replaces
// the count, and neither produces output. A tick or reinit request produces
// one count on out_valid/out_ready.
// Rate, set and reinit requests finish in the cycle they are taken. A tick
// runs on one shared unit, which forms a 64x64 multiply from four 32x32
// partial products and divides wide or narrow dividends one quotient bit
// at a time. An exponential tick runs the Horner series and squarings, a
// forward Euler tick a single multiply; a saturating tick skips both.
// The block takes no request while a tick is running, nor while a count
// waits at the output and out_ready is low; a waiting count holds steady.
// Configuration writes on cfg_we take effect at once; the user must issue
// them only while idle, unenforced by the block. Reset clears the count,
// the sums and both configuration registers and leaves no output pending.
`include "molecule_pool_exp_euler_step_core_assert.svh"

module molecule_pool_exp_euler_step_core
    import mpe_pkg::*;
#(
    parameter int COUNT_WIDTH = 48,
    localparam int CFG_WIDTH = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [CFG_WIDTH-1:0]   cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             kind,
    input  logic [COUNT_WIDTH-1:0] rate_in,
    input  logic [COUNT_WIDTH-1:0] rate_out,
    input  logic [COUNT_WIDTH-1:0] count_value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [COUNT_WIDTH-1:0] count
);

    localparam logic [63:0] CMAX = 64'({COUNT_WIDTH{1'b1}});

    seq_state_t state_reg, state_next;
    logic        issued_reg;
    logic [63:0] count_reg, in_sum_reg, out_sum_reg, init_reg;
    logic [31:0] step_reg;
    logic [63:0] t_reg, y_reg, t1_reg, dn_reg;
    logic [32:0] c_reg;
    logic [3:0]  k_reg;
    logic        out_valid_reg;
    logic [COUNT_WIDTH-1:0] out_count_reg;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    logic        accept;
    logic [63:0] shr32, shr63, x_sat, t2_sat, diff, fwd_count;

    mpe_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    assign accept = in_valid && in_ready;
    assign shr32  = alu_rsp.prod[95:32];
    assign shr63  = alu_rsp.prod[126:63];
    assign x_sat  = (alu_rsp.quo_ovf || alu_rsp.quo > XLIM) ? XLIM : alu_rsp.quo;
    assign t2_sat = (alu_rsp.quo_ovf || alu_rsp.quo > CMAX) ? CMAX : alu_rsp.quo;
    assign diff   = (in_sum_reg >= out_sum_reg) ? in_sum_reg - out_sum_reg
                                                : out_sum_reg - in_sum_reg;

    always_comb
    begin
        if (in_sum_reg >= out_sum_reg)
        begin
            fwd_count = (shr32 > CMAX) ? CMAX : sat_add(count_reg, shr32, CMAX);
        end
        else
        begin
            fwd_count = (count_reg > shr32) ? count_reg - shr32 : 64'd0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && kind == KIND_TICK)
                begin
                    state_next = (count_reg != 64'd0 && out_sum_reg != 64'd0) ? ST_BD : ST_FWD;
                end
            end
            ST_BD:   if (alu_rsp.done) state_next = ST_X;
            ST_X:    if (alu_rsp.done) state_next = (x_sat >= XLIM) ? ST_T1 : ST_HMUL;
            ST_HMUL: if (alu_rsp.done) state_next = ST_HDIV;
            ST_HDIV: if (alu_rsp.done) state_next = (k_reg == 4'd1) ? ST_SQ : ST_HMUL;
            ST_SQ:   if (alu_rsp.done && k_reg == SQUARINGS - 4'd1) state_next = ST_T1;
            ST_T1:   if (alu_rsp.done) state_next = ST_DN;
            ST_DN:   if (alu_rsp.done) state_next = ST_DA;
            ST_DA:   if (alu_rsp.done) state_next = ST_T2;
            ST_T2:   if (alu_rsp.done) state_next = ST_IDLE;
            ST_FWD:  if (alu_rsp.done) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready         = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
        alu_req.start    = (state_reg != ST_IDLE) && !issued_reg;
        alu_req.op       = OP_MUL;
        alu_req.wide     = 1'b1;
        alu_req.a        = 64'd0;
        alu_req.b        = 64'd0;
        alu_req.dividend = alu_rsp.prod;
        alu_req.den      = 64'd0;
        unique case (state_reg)
            ST_BD:
            begin
                alu_req.a = out_sum_reg;
                alu_req.b = 64'(step_reg);
            end
            ST_X:
            begin
                alu_req.op  = OP_DIV;
                alu_req.den = count_reg;
            end
            ST_HMUL:
            begin
                alu_req.a = y_reg;
                alu_req.b = t_reg;
            end
            ST_HDIV:
            begin
                alu_req.op       = OP_DIV;
                alu_req.wide     = 1'b0;
                alu_req.dividend = 128'(shr63);
                alu_req.den      = 64'(k_reg);
            end
            ST_SQ:
            begin
                alu_req.a = t_reg;
                alu_req.b = t_reg;
            end
            ST_T1:
            begin
                alu_req.a = count_reg;
                alu_req.b = 64'(c_reg);
            end
            ST_DN:
            begin
                alu_req.a = count_reg;
                alu_req.b = 64'h1_0000_0000 - 64'(c_reg);
            end
            ST_DA:
            begin
                alu_req.a = dn_reg;
                alu_req.b = in_sum_reg;
            end
            ST_T2:
            begin
                alu_req.op  = OP_DIV;
                alu_req.den = out_sum_reg;
            end
            ST_FWD:
            begin
                alu_req.a = diff;
                alu_req.b = 64'(step_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            count_reg     <= 64'd0;
            in_sum_reg    <= 64'd0;
            out_sum_reg   <= 64'd0;
            init_reg      <= 64'd0;
            step_reg      <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (alu_req.start)
            begin
                issued_reg <= 1'b1;
            end
            else if (alu_rsp.done)
            begin
                issued_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                if (cfg_index == REG_INIT_COUNT)
                begin
                    init_reg <= 64'(cfg_data[COUNT_WIDTH-1:0]);
                end
                else
                begin
                    step_reg <= cfg_data[31:0];
                end
            end

            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (accept)
            begin
                unique case (kind)
                    KIND_RATES:
                    begin
                        in_sum_reg  <= sat_add(in_sum_reg, 64'(rate_in), CMAX);
                        out_sum_reg <= sat_add(out_sum_reg, 64'(rate_out), CMAX);
                    end
                    KIND_SET:
                    begin
                        count_reg <= 64'(count_value);
                    end
                    KIND_REINIT:
                    begin
                        count_reg     <= init_reg;
                        in_sum_reg    <= 64'd0;
                        out_sum_reg   <= 64'd0;
                        out_valid_reg <= 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (alu_rsp.done && (state_reg == ST_T2 || state_reg == ST_FWD))
            begin
                count_reg     <= (state_reg == ST_T2) ? sat_add(t1_reg, t2_sat, CMAX) : fwd_count;
                in_sum_reg    <= 64'd0;
                out_sum_reg   <= 64'd0;
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && kind == KIND_REINIT)
        begin
            out_count_reg <= init_reg[COUNT_WIDTH-1:0];
        end
        if (alu_rsp.done)
        begin
            case (state_reg)
                ST_X:
                begin
                    y_reg <= x_sat << 23;
                    t_reg <= ONE63;
                    k_reg <= HORNER_TERMS;
                    c_reg <= 33'd0;
                end
                ST_HDIV:
                begin
                    t_reg <= ONE63 - alu_rsp.quo;
                    k_reg <= (k_reg == 4'd1) ? 4'd0 : k_reg - 4'd1;
                end
                ST_SQ:
                begin
                    t_reg <= shr63;
                    k_reg <= k_reg + 4'd1;
                    c_reg <= shr63[63:31];
                end
                ST_T1: t1_reg <= (shr32 > CMAX) ? CMAX : shr32;
                ST_DN: dn_reg <= shr32;
                ST_T2: out_count_reg <= sat_add(t1_reg, t2_sat, CMAX)
                                        [COUNT_WIDTH-1:0];
                ST_FWD: out_count_reg <= fwd_count[COUNT_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign count     = out_count_reg;

    `MPE_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, state_reg == ST_IDLE)
    `MPE_ASSERT_IMP(a_busy_no_out, clk, rst_n, state_reg != ST_IDLE, !out_valid_reg)
    `MPE_ASSERT_NXT(a_tick_done_out, clk, rst_n,
        alu_rsp.done && (state_reg == ST_T2 || state_reg == ST_FWD),
        out_valid_reg && state_reg == ST_IDLE)
    `MPE_ASSERT_IMP(a_start_free, clk, rst_n, alu_req.start, !alu_rsp.done)

endmodule

// File: tb/molecule_pool_exp_euler_step_core_test.sv
`timescale 1ns / 1ps

module molecule_pool_exp_euler_step_core_test;
    import mpe_pkg::*;

    localparam int CW = 48;
    localparam logic [63:0] CMAX = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] STEP_MAX = 64'h0000_0000_FFFF_FFFF;

    typedef struct {
        logic [1:0]  kind;
        logic [63:0] rin;
        logic [63:0] rout;
        logic [63:0] cval;
        bit          fixed;
        logic [63:0] fixed_count;
    } pool_row_t;

    logic          clk;
    logic          rst_n;
    logic          cfg_we;
    logic          cfg_index;
    logic [CW-1:0] cfg_data;
    logic          in_valid;
    logic          in_ready;
    logic [1:0]    kind;
    logic [CW-1:0] rate_in;
    logic [CW-1:0] rate_out;
    logic [CW-1:0] count_value;
    logic          out_valid;
    logic          out_ready;
    logic [CW-1:0] count;

    logic [63:0] pool_count, prod_sum, cons_sum, init_reg, step_reg;
    logic [63:0] count_queue[$];
    int          mismatches;
    int          send_idle_pct, recv_idle_pct;
    pool_row_t   rows[$];

    molecule_pool_exp_euler_step_core #(.COUNT_WIDTH(CW)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .rate_in(rate_in), .rate_out(rate_out), .count_value(count_value),
        .out_valid(out_valid), .out_ready(out_ready), .count(count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #60ms;
        $display("FAIL molecule_pool_exp_euler_step_core");
        $finish;
    end

    function automatic logic [63:0] prod_shr(logic [63:0] a, logic [63:0] b, int s);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> s;
        return p[63:0];
    endfunction

    function automatic logic [63:0] quot_sat(logic [127:0] num, logic [63:0] den,
                                             logic [63:0] lim);
        logic [127:0] q;
        if (den == 0)
            return lim;
        q = num / {64'd0, den};
        return (q > {64'd0, lim}) ? lim : q[63:0];
    endfunction

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
        return (b > CMAX - a) ? CMAX : a + b;
    endfunction

    function automatic logic [63:0] decay_factor(logic [63:0] x32);
        logic [63:0] y, t;
        y = x32 << 23;
        t = ONE63;
        for (int k = 10; k >= 1; k--)
            t = ONE63 - prod_shr(y, t, 63) / 64'(k);
        for (int i = 0; i < 8; i++)
            t = prod_shr(t, t, 63);
        return t >> 31;
    endfunction

    function automatic logic [63:0] advance_count(logic [63:0] n, logic [63:0] a,
                                                  logic [63:0] b, logic [63:0] d);
        logic [63:0] x32, c32, t1, dn, t2, diff, mag;
        if (n != 0 && b != 0)
        begin
            x32 = quot_sat({64'd0, b} * {64'd0, d}, n, XLIM);
            c32 = (x32 >= XLIM) ? 64'd0 : decay_factor(x32);
            t1 = prod_shr(n, c32, 32);
            dn = prod_shr(n, (64'd1 << 32) - c32, 32);
            t2 = quot_sat({64'd0, dn} * {64'd0, a}, b, CMAX);
            return add_sat((t1 > CMAX) ? CMAX : t1, t2);
        end
        diff = (a >= b) ? a - b : b - a;
        mag = prod_shr(diff, d, 32);
        if (a >= b)
            return (mag > CMAX) ? CMAX : add_sat(n, mag);
        return (n > mag) ? n - mag : 64'd0;
    endfunction

    function automatic logic [63:0] apply_request(logic [1:0] k, logic [63:0] ri,
                                                  logic [63:0] ro, logic [63:0] cv,
                                                  output bit emits);
        emits = 1'b0;
        case (k)
            KIND_RATES:
            begin
                prod_sum = add_sat(prod_sum, ri & CMAX);
                cons_sum = add_sat(cons_sum, ro & CMAX);
            end
            KIND_SET:
                pool_count = cv & CMAX;
            KIND_TICK:
            begin
                pool_count = advance_count(pool_count, prod_sum, cons_sum, step_reg);
                prod_sum = 0;
                cons_sum = 0;
                emits = 1'b1;
            end
            default:
            begin
                pool_count = init_reg;
                prod_sum = 0;
                cons_sum = 0;
                emits = 1'b1;
            end
        endcase
        return pool_count;
    endfunction

    task automatic write_reg(logic idx, logic [63:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CW-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_INIT_COUNT)
            init_reg = value & CMAX;
        else
            step_reg = value & STEP_MAX;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (count_queue.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic send_request(pool_row_t r);
        logic [63:0] predicted;
        bit          emits;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= r.kind;
        rate_in <= r.rin[CW-1:0];
        rate_out <= r.rout[CW-1:0];
        count_value <= r.cval[CW-1:0];
        do
            @(posedge clk);
        while (!in_ready);
        predicted = apply_request(r.kind, r.rin, r.rout, r.cval, emits);
        if (emits)
            count_queue.push_back(r.fixed ? r.fixed_count : predicted);
    endtask

    function automatic pool_row_t mk(logic [1:0] k, logic [63:0] ri, logic [63:0] ro,
                                     logic [63:0] cv, bit fx = 0, logic [63:0] fc = 0);
        pool_row_t r;
        r.kind = k;
        r.rin = ri;
        r.rout = ro;
        r.cval = cv;
        r.fixed = fx;
        r.fixed_count = fc;
        return r;
    endfunction

    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        v = {$urandom, $urandom} & CMAX;
        return v >> $urandom_range(0, 47);
    endfunction

    function automatic pool_row_t rand_request();
        int          pick;
        logic [1:0]  k;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            k = KIND_RATES;
        else if (pick < 70)
            k = KIND_TICK;
        else if (pick < 80)
            k = KIND_REINIT;
        else
            k = KIND_SET;
        return mk(k, rand_value(), rand_value(), rand_value());
    endfunction

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (count_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected count %h", count);
                end
                else
                begin
                    logic [63:0] want;
                    want = count_queue.pop_front();
                    if (count !== want[CW-1:0])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("count mismatch: expected %h actual %h", want[CW-1:0], count);
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_INIT_COUNT;
        cfg_data = '0;
        in_valid = 1'b0;
        kind = KIND_RATES;
        rate_in = '0;
        rate_out = '0;
        count_value = '0;
        out_ready = 1'b0;
        mismatches = 0;
        send_idle_pct = 37;
        recv_idle_pct = 55;
        pool_count = 0;
        prod_sum = 0;
        cons_sum = 0;
        init_reg = 0;
        step_reg = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(mk(KIND_TICK, 0, 0, 0, 1, 0));
        send_request(mk(KIND_REINIT, 0, 0, 0, 1, 0));
        drain();
        write_reg(REG_INIT_COUNT, CMAX);
        write_reg(REG_TIME_STEP, STEP_MAX);

        rows.push_back(mk(KIND_REINIT, 0, 0, 0, 1, CMAX));
        rows.push_back(mk(KIND_RATES, CMAX, CMAX, 0));
        rows.push_back(mk(KIND_RATES, 1, 1, 0));
        rows.push_back(mk(KIND_TICK, 0, 0, 0));
        rows.push_back(mk(KIND_SET, 0, 0, 0));
        rows.push_back(mk(KIND_RATES, 64'h5_0000, 0, 0));
        rows.push_back(mk(KIND_TICK, 0, 0, 0));
        rows.push_back(mk(KIND_SET, 0, 0, 0));
        rows.push_back(mk(KIND_RATES, 0, CMAX, 0));
        rows.push_back(mk(KIND_TICK, 0, 0, 0, 1, 0));
        rows.push_back(mk(KIND_SET, 0, 0, CMAX));
        rows.push_back(mk(KIND_RATES, CMAX, 0, 0));
        rows.push_back(mk(KIND_TICK, 0, 0, 0, 1, CMAX));
        rows.push_back(mk(KIND_SET, 0, 0, 1));
        rows.push_back(mk(KIND_RATES, 0, CMAX, 0));
        rows.push_back(mk(KIND_TICK, 0, 0, 0));
        rows.push_back(mk(KIND_SET, 0, 0, 64'h5555_5555_5555));
        rows.push_back(mk(KIND_RATES, 64'hAAAA_AAAA_AAAA, 64'h5555_5555_5555, 0));
        rows.push_back(mk(KIND_TICK, 0, 0, 0));
        rows.push_back(mk(KIND_SET, 0, 0, 64'h0001_0000_0000));
        rows.push_back(mk(KIND_RATES, 64'h0003_0000, 64'h0001_0000, 64'hAAAA_AAAA_AAAA));
        rows.push_back(mk(KIND_TICK, 0, 0, 0));
        rows.push_back(mk(KIND_RATES, 5, 7, 0));
        rows.push_back(mk(KIND_REINIT, 0, 0, 0, 1, CMAX));
        foreach (rows[i])
            send_request(rows[i]);

        for (int phase = 0; phase < 3; phase++)
        begin
            drain();
            if (phase == 0)
            begin
                write_reg(REG_INIT_COUNT, rand_value());
                write_reg(REG_TIME_STEP, {32'd0, $urandom});
            end
            else if (phase == 1)
            begin
                send_idle_pct = 55;
                recv_idle_pct = 37;
                write_reg(REG_INIT_COUNT, 0);
                write_reg(REG_TIME_STEP, 1);
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                write_reg(REG_INIT_COUNT, rand_value());
                write_reg(REG_TIME_STEP, STEP_MAX);
            end
            for (int i = 0; i < 310; i++)
                send_request(rand_request());
        end
        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && count_queue.size() == 0)
            $display("PASS molecule_pool_exp_euler_step_core");
        else
            $display("FAIL molecule_pool_exp_euler_step_core");
        $finish;
    end

endmodule

// File: molecule_pool_exp_euler_step_core.f
+incdir+sv
sv/mpe_pkg.sv
sv/mpe_alu.sv
sv/molecule_pool_exp_euler_step_core.sv
tb/molecule_pool_exp_euler_step_core_test.sv
